[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the stroke expander
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define ASSERT_SYNC(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define ASSERT_SYNC_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/spqe_pkg.sv]
// ----------------------------------------------------------------------------
// spqe_pkg
// shared codes, types and helpers of the path stroke quad expander
// ----------------------------------------------------------------------------
package spqe_pkg;

  localparam int CoordW = 32;
  localparam int SwW    = 24;
  localparam int QuoW   = 25;
  localparam int RootSteps = 32;

  localparam logic [SwW-1:0] SwReset = 24'd65536;

  // path command codes
  localparam logic [3:0] OP_CLOSE  = 4'd0;
  localparam logic [3:0] OP_MOVE   = 4'd1;
  localparam logic [3:0] OP_LINE   = 4'd2;
  localparam logic [3:0] OP_HLINE  = 4'd3;
  localparam logic [3:0] OP_VLINE  = 4'd4;
  localparam logic [3:0] OP_QUAD   = 4'd5;
  localparam logic [3:0] OP_CUBIC  = 4'd6;
  localparam logic [3:0] OP_SCUBIC = 4'd8;
  localparam logic [3:0] OP_ARC0   = 4'd9;
  localparam logic [3:0] OP_ARC1   = 4'd10;
  localparam logic [3:0] OP_ARC2   = 4'd11;
  localparam logic [3:0] OP_ARC3   = 4'd12;

  // datapath commands
  localparam logic [3:0] CMD_NONE = 4'd0;
  localparam logic [3:0] CMD_PREP = 4'd1;
  localparam logic [3:0] CMD_SQX  = 4'd2;
  localparam logic [3:0] CMD_SQY  = 4'd3;
  localparam logic [3:0] CMD_ROOT = 4'd4;
  localparam logic [3:0] CMD_MULX = 4'd5;
  localparam logic [3:0] CMD_MULY = 4'd6;
  localparam logic [3:0] CMD_DIV  = 4'd7;
  localparam logic [3:0] CMD_LOAD = 4'd8;

  typedef struct packed {
    logic [3:0] op;
    logic [4:0] step;
    logic       accept;
  } cmd_t;

  typedef struct packed {
    logic draw;
  } sts_t;

  function automatic logic [CoordW-1:0] sat32(input logic signed [CoordW:0] v);
    logic [CoordW-1:0] r;
    if (v[CoordW] != v[CoordW-1]) begin
      r = v[CoordW] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/spqe_ctrl.sv]
// ----------------------------------------------------------------------------
// spqe_ctrl
// sequencer for command intake, root, divide and result handoff
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spqe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  spqe_pkg::sts_t sts_i,
  output spqe_pkg::cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_PREP = 4'd1;
  localparam logic [3:0] ST_SQX  = 4'd2;
  localparam logic [3:0] ST_SQY  = 4'd3;
  localparam logic [3:0] ST_ROOT = 4'd4;
  localparam logic [3:0] ST_MULX = 4'd5;
  localparam logic [3:0] ST_DIVX = 4'd6;
  localparam logic [3:0] ST_MULY = 4'd7;
  localparam logic [3:0] ST_DIVY = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  localparam logic [4:0] RootLast = 5'(spqe_pkg::RootSteps - 1);
  localparam logic [4:0] DivLast  = 5'(spqe_pkg::QuoW - 1);

  logic [3:0] st_q, st_d;
  logic [4:0] cnt_q, cnt_d;
  logic       ovld_q, ovld_d;
  logic       in_fire, load;

  assign in_ready_o  = (st_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = ovld_q;
  assign load        = (st_q == ST_FIN) && (!ovld_q || out_ready_i);

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    cmd_o = '{op: spqe_pkg::CMD_NONE, step: cnt_q, accept: in_fire};
    case (st_q)
      ST_IDLE: begin
        if (in_fire && sts_i.draw) st_d = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.op = spqe_pkg::CMD_PREP;
        st_d = ST_SQX;
      end
      ST_SQX: begin
        cmd_o.op = spqe_pkg::CMD_SQX;
        st_d = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.op = spqe_pkg::CMD_SQY;
        cnt_d = '0;
        st_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.op = spqe_pkg::CMD_ROOT;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == RootLast) st_d = ST_MULX;
      end
      ST_MULX: begin
        cmd_o.op = spqe_pkg::CMD_MULX;
        cnt_d = '0;
        st_d = ST_DIVX;
      end
      ST_DIVX: begin
        cmd_o.op = spqe_pkg::CMD_DIV;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DivLast) st_d = ST_MULY;
      end
      ST_MULY: begin
        cmd_o.op = spqe_pkg::CMD_MULY;
        cnt_d = '0;
        st_d = ST_DIVY;
      end
      ST_DIVY: begin
        cmd_o.op = spqe_pkg::CMD_DIV;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DivLast) st_d = ST_FIN;
      end
      ST_FIN: begin
        if (load) begin
          cmd_o.op = spqe_pkg::CMD_LOAD;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ovld_d = ovld_q;
    if (load) ovld_d = 1'b1;
    else if (out_ready_i) ovld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  `ASSERT_SYNC(a_fin_holds, (st_q == ST_FIN && ovld_q && !out_ready_i) |=> (st_q == ST_FIN), "finished word lost while output full")
  `ASSERT_SYNC(a_root_len, (st_q == ST_ROOT && cnt_q == RootLast) |=> (st_q == ST_MULX), "root did not end after its last step")
  `ASSERT_SYNC(a_nodraw_idle, (in_fire && !sts_i.draw) |=> (st_q == ST_IDLE), "command without segment left idle")

endmodule

[rtl/core/spqe_dp.sv]
// ----------------------------------------------------------------------------
// spqe_dp
// pen state, shared multiplier, root and divide steps, corner output
// ----------------------------------------------------------------------------
module spqe_dp (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [23:0]            cfg_wdata_i,
  input  logic [3:0]             op_i,
  input  logic                   rel_i,
  input  logic [191:0]           coords_i,
  input  spqe_pkg::cmd_t         cmd_i,
  output spqe_pkg::sts_t         sts_o,
  output logic [255:0]           corners_o
);

  logic [31:0] pen_x_q, pen_y_q, sub_x_q, sub_y_q;
  logic [23:0] sw_q;
  logic [31:0] x0_q, y0_q, x1_q, y1_q;
  logic        sgnx_q, sgny_q;
  logic [30:0] ax_q, ay_q;
  logic [63:0] acc_q, root_q;
  logic [32:0] rem_q;
  logic [24:0] nq_q, mx_q;
  logic [255:0] corners_q;

  logic [31:0] ca, cb, cc, cd, ce, cf;
  logic [31:0] ex, ey, nx, ny, endx, endy;
  logic        is_path, is_draw;

  assign ca = coords_i[31:0];
  assign cb = coords_i[63:32];
  assign cc = coords_i[95:64];
  assign cd = coords_i[127:96];
  assign ce = coords_i[159:128];
  assign cf = coords_i[191:160];

  // intake decode
  always_comb begin
    ex = ca;
    ey = cb;
    case (op_i)
      spqe_pkg::OP_HLINE: ey = '0;
      spqe_pkg::OP_VLINE: begin
        ex = '0;
        ey = ca;
      end
      spqe_pkg::OP_QUAD, spqe_pkg::OP_SCUBIC: begin
        ex = cc;
        ey = cd;
      end
      spqe_pkg::OP_CUBIC: begin
        ex = ce;
        ey = cf;
      end
      spqe_pkg::OP_ARC0, spqe_pkg::OP_ARC1, spqe_pkg::OP_ARC2, spqe_pkg::OP_ARC3: begin
        ex = cd;
        ey = ce;
      end
      default: begin
        ex = ca;
        ey = cb;
      end
    endcase
    is_path = op_i inside {spqe_pkg::OP_LINE, spqe_pkg::OP_HLINE, spqe_pkg::OP_VLINE,
                           spqe_pkg::OP_QUAD, spqe_pkg::OP_CUBIC, spqe_pkg::OP_SCUBIC,
                           spqe_pkg::OP_ARC0, spqe_pkg::OP_ARC1, spqe_pkg::OP_ARC2,
                           spqe_pkg::OP_ARC3};
    is_draw = op_i inside {spqe_pkg::OP_CLOSE, spqe_pkg::OP_LINE, spqe_pkg::OP_HLINE,
                           spqe_pkg::OP_VLINE, spqe_pkg::OP_QUAD, spqe_pkg::OP_CUBIC,
                           spqe_pkg::OP_SCUBIC};
    if (op_i == spqe_pkg::OP_VLINE) nx = pen_x_q;
    else if (rel_i) nx = spqe_pkg::sat32($signed({pen_x_q[31], pen_x_q}) + $signed({ex[31], ex}));
    else nx = ex;
    if (op_i == spqe_pkg::OP_HLINE) ny = pen_y_q;
    else if (rel_i) ny = spqe_pkg::sat32($signed({pen_y_q[31], pen_y_q}) + $signed({ey[31], ey}));
    else ny = ey;
    endx = (op_i == spqe_pkg::OP_CLOSE) ? sub_x_q : nx;
    endy = (op_i == spqe_pkg::OP_CLOSE) ? sub_y_q : ny;
  end

  assign sts_o.draw = is_draw && ((endx != pen_x_q) || (endy != pen_y_q));

  // segment normal magnitudes
  logic [32:0] dxs, dys, mgx, mgy;
  logic        halve;
  assign dxs   = {y1_q[31], y1_q} - {y0_q[31], y0_q};
  assign dys   = {x0_q[31], x0_q} - {x1_q[31], x1_q};
  assign mgx   = dxs[32] ? (33'd0 - dxs) : dxs;
  assign mgy   = dys[32] ? (33'd0 - dys) : dys;
  assign halve = (|mgx[32:31]) || (|mgy[32:31]);

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  always_comb begin
    case (cmd_i.op)
      spqe_pkg::CMD_SQX: begin
        mul_a = {1'b0, ax_q};
        mul_b = {1'b0, ax_q};
      end
      spqe_pkg::CMD_SQY: begin
        mul_a = {1'b0, ay_q};
        mul_b = {1'b0, ay_q};
      end
      spqe_pkg::CMD_MULX: begin
        mul_a = {8'd0, sw_q};
        mul_b = {1'b0, ax_q};
      end
      default: begin
        mul_a = {8'd0, sw_q};
        mul_b = {1'b0, ay_q};
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // root step
  logic [5:0]  rsh;
  logic [63:0] rbit, rtry;
  logic        rge;
  assign rsh  = 6'd62 - {cmd_i.step, 1'b0};
  assign rbit = 64'd1 << rsh;
  assign rtry = root_q + rbit;
  assign rge  = (acc_q >= rtry);

  // divide step
  logic [31:0] len;
  logic [32:0] dvs;
  logic [33:0] dtry, ddif;
  logic        dge;
  logic [55:0] num;
  assign len  = (root_q[31:0] == 32'd0) ? 32'd1 : root_q[31:0];
  assign dvs  = {len, 1'b0};
  assign dtry = {rem_q, nq_q[24]};
  assign dge  = (dtry >= {1'b0, dvs});
  assign ddif = dtry - {1'b0, dvs};
  assign num  = prod[55:0] + {24'd0, len};

  // corners
  logic signed [32:0] offx, offy;
  logic [255:0]       corn;
  always_comb begin
    offx = sgnx_q ? -$signed({8'd0, mx_q}) : $signed({8'd0, mx_q});
    offy = sgny_q ? -$signed({8'd0, nq_q}) : $signed({8'd0, nq_q});
    corn[31:0]    = spqe_pkg::sat32($signed({x0_q[31], x0_q}) + offx);
    corn[63:32]   = spqe_pkg::sat32($signed({y0_q[31], y0_q}) + offy);
    corn[95:64]   = spqe_pkg::sat32($signed({x0_q[31], x0_q}) - offx);
    corn[127:96]  = spqe_pkg::sat32($signed({y0_q[31], y0_q}) - offy);
    corn[159:128] = spqe_pkg::sat32($signed({x1_q[31], x1_q}) + offx);
    corn[191:160] = spqe_pkg::sat32($signed({y1_q[31], y1_q}) + offy);
    corn[223:192] = spqe_pkg::sat32($signed({x1_q[31], x1_q}) - offx);
    corn[255:224] = spqe_pkg::sat32($signed({y1_q[31], y1_q}) - offy);
  end

  assign corners_o = corners_q;

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_x_q <= '0;
      pen_y_q <= '0;
      sub_x_q <= '0;
      sub_y_q <= '0;
      sw_q    <= spqe_pkg::SwReset;
    end else begin
      if (cfg_we_i) sw_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        if (op_i == spqe_pkg::OP_CLOSE) begin
          pen_x_q <= sub_x_q;
          pen_y_q <= sub_y_q;
        end else if (op_i == spqe_pkg::OP_MOVE) begin
          pen_x_q <= ca;
          pen_y_q <= cb;
          sub_x_q <= ca;
          sub_y_q <= cb;
        end else if (is_path) begin
          pen_x_q <= nx;
          pen_y_q <= ny;
        end
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x0_q <= pen_x_q;
      y0_q <= pen_y_q;
      x1_q <= endx;
      y1_q <= endy;
    end
    case (cmd_i.op)
      spqe_pkg::CMD_PREP: begin
        sgnx_q <= dxs[32];
        sgny_q <= dys[32];
        ax_q   <= halve ? mgx[31:1] : mgx[30:0];
        ay_q   <= halve ? mgy[31:1] : mgy[30:0];
      end
      spqe_pkg::CMD_SQX: acc_q <= prod;
      spqe_pkg::CMD_SQY: begin
        acc_q  <= acc_q + prod;
        root_q <= '0;
      end
      spqe_pkg::CMD_ROOT: begin
        if (rge) begin
          acc_q  <= acc_q - rtry;
          root_q <= (root_q >> 1) + rbit;
        end else begin
          root_q <= root_q >> 1;
        end
      end
      spqe_pkg::CMD_MULX, spqe_pkg::CMD_MULY: begin
        if (cmd_i.op == spqe_pkg::CMD_MULY) mx_q <= nq_q;
        rem_q <= {2'd0, num[55:25]};
        nq_q  <= num[24:0];
      end
      spqe_pkg::CMD_DIV: begin
        rem_q <= dge ? ddif[32:0] : dtry[32:0];
        nq_q  <= {nq_q[23:0], dge};
      end
      spqe_pkg::CMD_LOAD: corners_q <= corn;
      default: ;
    endcase
  end

endmodule

[rtl/core/path_stroke_quad_expander.sv]
// ----------------------------------------------------------------------------
// path_stroke_quad_expander
// turns path commands into stroke quads, one per drawn segment
// ----------------------------------------------------------------------------
// sequence: a drawing command runs the prep step, two squares and the root,
//   then a multiply and a divide for each of x and y, and loads its word once
//   the output register is free; no new command is taken before that load
// move, arc, unknown and zero-length commands leave the sequencer idle; the
//   bit-serial square root (32 steps) and two restoring divides (25 steps each) run in turn
// reset: async active low; pen and subpath start clear to zero, width to 1.0
module path_stroke_quad_expander (
  input  logic         clk_i,
  input  logic         rst_ni,
  // stroke width, unsigned q8.16
  input  logic         cfg_we_i,
  input  logic [23:0]  cfg_wdata_i,
  // command word
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // coord_a, coord_b, ..., coord_f
  input  logic [4:0]   s_axis_tuser,   // operation[3:0], relative[4]
  // quad word
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata    // corner0_x, corner0_y, ..., corner3_y
);

  spqe_pkg::cmd_t cmd;
  spqe_pkg::sts_t sts;

  // sequencer: intake, iteration counts, output register handoff
  spqe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: pen state, multiplier, root, divider, corner saturation
  spqe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .op_i        (s_axis_tuser[3:0]),
    .rel_i       (s_axis_tuser[4]),
    .coords_i    (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .corners_o   (m_axis_tdata)
  );

endmodule

[sim/tb_path_stroke_quad_expander.sv]
// ----------------------------------------------------------------------------
// tb_path_stroke_quad_expander
// self-checking bench: path commands go in on the command stream, each quad
// word is checked field by field against a built-in predictor of pen state,
// chord normal and saturated corners, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module tb_path_stroke_quad_expander;

  // command codes the block must ignore
  localparam logic [3:0] OP_UNKNOWN7  = 4'd7;
  localparam logic [3:0] OP_UNKNOWN13 = 4'd13;
  localparam logic [3:0] OP_UNKNOWN14 = 4'd14;
  localparam logic [3:0] OP_UNKNOWN15 = 4'd15;

  localparam int  DrainCycles = 120;      // idle wait after the last owed quad
  localparam int  HoldCycles  = 700;      // long receiver hold-off
  localparam longint CycleLimit = 3000000;
  localparam longint MaxPos = 64'sd2147483647;
  localparam longint MinNeg = -64'sd2147483648;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [23:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata = '0;   // coord_a, coord_b, ..., coord_f
  logic [4:0]   s_axis_tuser = '0;   // operation[3:0], relative[4]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;        // corner0_x, corner0_y, ..., corner3_y

  path_stroke_quad_expander dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor state, mirrors the block after reset
  longint          pen_x, pen_y, sub_x, sub_y;
  longint unsigned width_q816 = 64'(spqe_pkg::SwReset);

  logic [255:0] quad_q[$];    // quads still owed by the block
  int  errors = 0;
  bit  hold_off = 1'b0;       // asks the receiver for one long stall
  bit  calm = 1'b0;           // no idling on either side while set
  longint cycles = 0;

  string corner_name[8] = '{"corner0_x", "corner0_y", "corner1_x", "corner1_y",
                            "corner2_x", "corner2_y", "corner3_x", "corner3_y"};

  function automatic longint clamp32(longint v);
    if (v > MaxPos) return MaxPos;
    if (v < MinNeg) return MinNeg;
    return v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // widen the chord (x0,y0)-(x1,y1) by half the stroke width on each side
  function automatic bit stroke_quad(longint x0, longint y0, longint x1, longint y1,
                                     output logic [255:0] quad);
    longint dx, dy, offx, offy, sx, sy, px, py;
    longint unsigned ax, ay, len, mx, my;
    quad = '0;
    if (x0 == x1 && y0 == y1) return 1'b0;
    dx = y1 - y0;
    dy = x0 - x1;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    // keep the squares inside 64 bits
    if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
      ax = ax >> 1;
      ay = ay >> 1;
    end
    len = int_root(ax * ax + ay * ay);
    if (len == 0) len = 1;
    mx = (width_q816 * ax + len) / (2 * len);
    my = (width_q816 * ay + len) / (2 * len);
    offx = (dx < 0) ? -longint'(mx) : longint'(mx);
    offy = (dy < 0) ? -longint'(my) : longint'(my);
    for (int k = 0; k < 4; k++) begin
      px = (k < 2) ? x0 : x1;
      py = (k < 2) ? y0 : y1;
      sx = k[0] ? -offx : offx;
      sy = k[0] ? -offy : offy;
      quad[64*k +: 32]    = 32'(clamp32(px + sx));
      quad[64*k+32 +: 32] = 32'(clamp32(py + sy));
    end
    return 1'b1;
  endfunction

  // advance the pen for one command, returns 1 when a quad is owed
  function automatic bit track_command(logic [3:0] op, bit rel, logic [191:0] crd,
                                       output logic [255:0] quad);
    longint c[6];
    longint ox, oy, nx, ny, ex, ey;
    ox = pen_x; oy = pen_y; nx = pen_x; ny = pen_y; ex = 0; ey = 0;
    quad = '0;
    for (int i = 0; i < 6; i++) c[i] = longint'($signed(crd[32*i +: 32]));
    case (op)
      spqe_pkg::OP_CLOSE: begin
        pen_x = sub_x;
        pen_y = sub_y;
        return stroke_quad(ox, oy, sub_x, sub_y, quad);
      end
      spqe_pkg::OP_MOVE: begin
        // always absolute
        pen_x = c[0]; sub_x = c[0];
        pen_y = c[1]; sub_y = c[1];
        return 1'b0;
      end
      spqe_pkg::OP_LINE: begin ex = c[0]; ey = c[1]; end
      spqe_pkg::OP_HLINE: ex = c[0];
      spqe_pkg::OP_VLINE: ey = c[0];
      spqe_pkg::OP_QUAD, spqe_pkg::OP_SCUBIC: begin ex = c[2]; ey = c[3]; end
      spqe_pkg::OP_CUBIC: begin ex = c[4]; ey = c[5]; end
      spqe_pkg::OP_ARC0, spqe_pkg::OP_ARC1, spqe_pkg::OP_ARC2,
      spqe_pkg::OP_ARC3: begin ex = c[3]; ey = c[4]; end
      default: return 1'b0;
    endcase
    if (op != spqe_pkg::OP_VLINE) nx = rel ? clamp32(ox + ex) : ex;
    if (op != spqe_pkg::OP_HLINE) ny = rel ? clamp32(oy + ey) : ey;
    pen_x = nx;
    pen_y = ny;
    // arcs only move the pen
    if (op >= spqe_pkg::OP_ARC0) return 1'b0;
    return stroke_quad(ox, oy, nx, ny, quad);
  endfunction

  // coordinate with a bias toward extremes and small values
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endcase
  endfunction

  function automatic logic [191:0] pick_coords();
    logic [191:0] r;
    for (int i = 0; i < 6; i++) r[32*i +: 32] = pick_coord();
    return r;
  endfunction

  // offer one command word, predict at the accepting edge
  task automatic send_cmd(logic [3:0] op, bit rel, logic [191:0] crd);
    int gap;
    logic [255:0] quad;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= crd;
    s_axis_tuser  <= {rel, op};
    do @(posedge clk_i); while (!s_axis_tready);
    if (track_command(op, rel, crd, quad)) quad_q = {quad_q, quad};
  endtask

  // stop offering and wait until every owed quad has arrived
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (quad_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_width(logic [23:0] w);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    width_q816 = 64'(w);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off = 1'b0;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // quad checker
  always @(posedge clk_i) begin
    logic [255:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (quad_q.size() == 0) begin
        $error("quad word with none expected: %h", m_axis_tdata);
        errors++;
      end else begin
        want = quad_q.pop_front();
        for (int k = 0; k < 8; k++)
          if (want[32*k +: 32] !== m_axis_tdata[32*k +: 32]) begin
            $error("%s expected %h actual %h", corner_name[k],
                   want[32*k +: 32], m_axis_tdata[32*k +: 32]);
            errors++;
          end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // every command kind, reset width, extremes and the special cases
  task automatic test_directed();
    send_cmd(spqe_pkg::OP_LINE, 1'b0, {128'd0, 32'sd0, 32'sd65536});   // from origin
    send_cmd(spqe_pkg::OP_HLINE, 1'b1, {160'd0, 32'sd131072});
    send_cmd(spqe_pkg::OP_VLINE, 1'b1, {160'd0, -32'sd131072});
    send_cmd(spqe_pkg::OP_MOVE, 1'b1, {128'd0, 32'sd1000, 32'sd2000});  // relative ignored
    send_cmd(spqe_pkg::OP_QUAD, 1'b0, {64'd0, 32'sd5000, 32'sd7000, 64'd0});
    send_cmd(spqe_pkg::OP_SCUBIC, 1'b1, {64'd0, -32'sd300, 32'sd900, 64'd0});
    send_cmd(spqe_pkg::OP_CUBIC, 1'b0, {32'sd10, 32'sd20, 128'd0});
    send_cmd(spqe_pkg::OP_CUBIC, 1'b0, {32'sd10, 32'sd20, 128'd0});     // zero length
    send_cmd(spqe_pkg::OP_CLOSE, 1'b1, pick_coords());
    send_cmd(spqe_pkg::OP_CLOSE, 1'b0, '0);                              // pen at start
    send_cmd(spqe_pkg::OP_ARC0, 1'b0, {32'd0, 32'sd50, 32'sd60, 96'd0});
    send_cmd(spqe_pkg::OP_ARC1, 1'b1, {32'd0, 32'sd5, 32'sd6, 96'd0});
    send_cmd(spqe_pkg::OP_ARC2, 1'b0, pick_coords());
    send_cmd(spqe_pkg::OP_ARC3, 1'b1, pick_coords());
    send_cmd(OP_UNKNOWN7, 1'b0, pick_coords());
    send_cmd(OP_UNKNOWN13, 1'b1, pick_coords());
    send_cmd(OP_UNKNOWN14, 1'b0, pick_coords());
    send_cmd(OP_UNKNOWN15, 1'b1, pick_coords());
    // opposite corners of the coordinate range, then relative saturation
    send_cmd(spqe_pkg::OP_MOVE, 1'b0, {128'd0, 32'h8000_0000, 32'h8000_0000});
    send_cmd(spqe_pkg::OP_LINE, 1'b0, {128'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_cmd(spqe_pkg::OP_LINE, 1'b1, {128'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    send_cmd(spqe_pkg::OP_HLINE, 1'b0, {160'd0, 32'h8000_0000});
    send_cmd(spqe_pkg::OP_VLINE, 1'b1, {160'd0, 32'h8000_0000});
    send_cmd(spqe_pkg::OP_CLOSE, 1'b0, '0);
  endtask

  // width extremes with segments near the corners of the range
  task automatic test_width_extremes();
    logic [23:0] w[4] = '{24'h000000, 24'hFFFFFF, 24'h000001, 24'h800000};
    for (int i = 0; i < 4; i++) begin
      set_width(w[i]);
      send_cmd(spqe_pkg::OP_MOVE, 1'b0, {128'd0, 32'h7FFF_F000, 32'h8000_1000});
      send_cmd(spqe_pkg::OP_LINE, 1'b0, {128'd0, 32'h8000_0100, 32'h7FFF_FF00});
      send_cmd(spqe_pkg::OP_HLINE, 1'b1, {160'd0, 32'sd3});
      send_cmd(spqe_pkg::OP_VLINE, 1'b0, {160'd0, 32'sd0});
      send_cmd(spqe_pkg::OP_CLOSE, 1'b0, '0);
    end
  endtask

  // receiver holds off while the sender keeps offering, then the sender waits
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++)
      send_cmd(spqe_pkg::OP_LINE, 1'($urandom_range(0, 1)), pick_coords());
    drain();
  endtask

  // subpaths with random content, some noise and broken sequences
  task automatic test_random_paths();
    int sent;
    int seg_n;
    logic [3:0] op;
    logic [23:0] w;
    sent = 0;
    while (sent < 1900) begin
      if (sent % 400 < 8 && sent > 0) begin
        case ($urandom_range(0, 3))
          0: w = 24'h000000;
          1: w = 24'hFFFFFF;
          default: w = 24'($urandom_range(0, 24'h03FFFF));
        endcase
        set_width(w);
        calm = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        // noise: any code, any flag, any coordinates
        send_cmd(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), pick_coords());
        sent++;
      end else begin
        if ($urandom_range(0, 4) != 0) begin
          send_cmd(spqe_pkg::OP_MOVE, 1'($urandom_range(0, 1)), pick_coords());
          sent++;
        end
        seg_n = $urandom_range(1, 8);
        for (int i = 0; i < seg_n; i++) begin
          case ($urandom_range(0, 9))
            0: op = spqe_pkg::OP_LINE;
            1: op = spqe_pkg::OP_HLINE;
            2: op = spqe_pkg::OP_VLINE;
            3: op = spqe_pkg::OP_QUAD;
            4: op = spqe_pkg::OP_CUBIC;
            5: op = spqe_pkg::OP_SCUBIC;
            6: op = 4'(spqe_pkg::OP_ARC0 + $urandom_range(0, 3));
            default: op = spqe_pkg::OP_LINE;
          endcase
          send_cmd(op, 1'($urandom_range(0, 1)), pick_coords());
          sent++;
        end
        if ($urandom_range(0, 1) != 0) begin
          send_cmd(spqe_pkg::OP_CLOSE, 1'($urandom_range(0, 1)), pick_coords());
          sent++;
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    pen_x = 0; pen_y = 0; sub_x = 0; sub_y = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_width_extremes();
    set_width(spqe_pkg::SwReset);
    test_backpressure();
    test_random_paths();
    drain();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
